FILE: src/assert_macros.svh
// Assertion macros used by the servo ramp datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SAR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SAR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: src/sar_pkg.sv
// Shared types and constants of the servo angle ramp generator.
package sar_pkg;

   localparam int ANGLE_W    = 24;
   localparam int STEP_W     = 25;
   localparam int TARGET_W   = 17;
   localparam int DUR_W      = 16;
   localparam int INTV_W     = 16;
   localparam int CHAN_W     = 4;
   localparam int OFF_W      = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] ANGLE_MAX_IN  = 16'd46080;
   localparam logic [INTV_W-1:0] INTV_RESET = 16'd20;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_MOVE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 1'b1;

   // Off count = floor((455*a + 2^30*1.25) / (25 * 2^19)).
   localparam int          OFF_V_W   = 33;
   localparam int          OFF_X_LSB = 19;
   localparam int          OFF_X_W   = OFF_V_W - OFF_X_LSB;
   localparam int          RECIP_W   = 15;
   localparam int          OFF_P_W   = 31;
   localparam logic [OFF_V_W-1:0] OFF_MUL = 33'd455;
   localparam logic [OFF_V_W-1:0] OFF_ADD = 33'd1342177280;
   // ceil(2^19 / 25); exact for every quotient below 2^14.
   localparam logic [RECIP_W-1:0] OFF_RECIP = 15'd20972;

   // Divider: radix 2, two quotient bits per cycle.
   localparam int DIV_N_W      = 24;
   localparam int DIV_D_W      = 16;
   localparam int DIV_PER_CYC  = 2;
   localparam int DIV_ITER     = DIV_N_W / DIV_PER_CYC;
   localparam int DIV_CNT_W    = $clog2(DIV_ITER + 1);

   typedef struct packed {
      logic capture;
      logic tick;
      logic move_start;
      logic move_eval;
      logic div2_start;
      logic move_ramp;
      logic off_mul;
      logic off_scale;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic steps_zero;
      logic rsp_free;
   } status_type;

endpackage

FILE: src/sar_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
module sar_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sar_pkg::DIV_N_W-1:0]  dividend,
   input  logic [sar_pkg::DIV_D_W-1:0]  divisor,
   output logic [sar_pkg::DIV_N_W-1:0]  quotient,
   output logic                         done
);

   logic [sar_pkg::DIV_N_W-1:0]   quo_ff, quo_in;
   logic [sar_pkg::DIV_D_W-1:0]   rem_ff, rem_in;
   logic [sar_pkg::DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [sar_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          done_ff, done_in;

   always_comb begin
      logic [sar_pkg::DIV_D_W:0]   part;
      logic [sar_pkg::DIV_D_W-1:0] r;
      logic [sar_pkg::DIV_N_W-1:0] q;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      r       = rem_ff;
      q       = quo_ff;
      part    = '0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = sar_pkg::DIV_CNT_W'(sar_pkg::DIV_ITER);
      end else if (cnt_ff != '0) begin
         for (int i = 0; i < sar_pkg::DIV_PER_CYC; i++) begin
            part = {r, q[sar_pkg::DIV_N_W-1]};
            q    = {q[sar_pkg::DIV_N_W-2:0], 1'b0};
            if (part >= {1'b0, dvs_ff}) begin
               part = part - {1'b0, dvs_ff};
               q[0] = 1'b1;
            end
            // The remainder stays below the divisor, so it fits again.
            r = part[sar_pkg::DIV_D_W-1:0];
         end
         quo_in  = q;
         rem_in  = r;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == sar_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

FILE: src/sar_datapath.sv
// Ramp state, divider operands, off count arithmetic and result register.
`include "assert_macros.svh"

module sar_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  sar_pkg::cmd_type                  cmd,
   output sar_pkg::status_type               status,
   input  logic                              req_mode,
   input  logic signed [sar_pkg::TARGET_W-1:0] req_target_angle,
   input  logic [sar_pkg::DUR_W-1:0]         req_duration_ms,
   input  logic                              csr_wr_en,
   input  logic [sar_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sar_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_write_valid,
   output logic [sar_pkg::CHAN_W-1:0]        rsp_out_channel,
   output logic [sar_pkg::OFF_W-1:0]         rsp_off_count,
   output logic                              rsp_move_done
);

   localparam logic [sar_pkg::ANGLE_W-1:0] ANGLE_LIMIT = {sar_pkg::ANGLE_MAX_IN, 8'd0};

   // Configuration.
   logic [sar_pkg::CHAN_W-1:0] chan_ff;
   logic [sar_pkg::INTV_W-1:0] intv_ff;
   logic [sar_pkg::INTV_W-1:0] intv_eff;

   // Captured beat.
   logic                                 mode_ff;
   logic signed [sar_pkg::TARGET_W-1:0]  tgt_ff;
   logic [sar_pkg::DUR_W-1:0]            dur_ff;

   // Ramp state.
   logic [sar_pkg::ANGLE_W-1:0] cur_ff, cur_in;
   logic [sar_pkg::ANGLE_W-1:0] goal_ff, goal_in;
   logic [sar_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        active_ff, active_in;
   logic [sar_pkg::INTV_W-1:0]  elap_ff, elap_in;
   logic                        wr_ff, wr_in;

   // Move scratch.
   logic [sar_pkg::DIV_D_W-1:0] steps_ff, steps_in;
   logic [sar_pkg::ANGLE_W-1:0] mag_ff, mag_in;
   logic                        neg_ff, neg_in;

   // Off count pipeline.
   logic [sar_pkg::OFF_V_W-1:0] offv_ff;
   logic [sar_pkg::OFF_W-1:0]   off_ff;
   logic [sar_pkg::OFF_P_W-1:0] scaled;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_wv_ff;
   logic [sar_pkg::CHAN_W-1:0]  rsp_ch_ff;
   logic [sar_pkg::OFF_W-1:0]   rsp_off_ff;
   logic                        rsp_done_ff;

   // Divider.
   logic                        div_start;
   logic [sar_pkg::DIV_N_W-1:0] div_num;
   logic [sar_pkg::DIV_D_W-1:0] div_den;
   logic [sar_pkg::DIV_N_W-1:0] div_quo;
   logic                        div_done;

   assign intv_eff = (intv_ff == '0) ? sar_pkg::INTV_W'(1) : intv_ff;

   assign div_start = cmd.move_start | cmd.div2_start;
   assign div_num   = cmd.div2_start ? mag_ff
                                     : {{(sar_pkg::DIV_N_W-sar_pkg::DUR_W){1'b0}}, dur_ff};
   assign div_den   = cmd.div2_start ? steps_ff : intv_eff;

   sar_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quo),
      .done     (div_done)
   );

   always_comb begin
      logic [15:0]                        clamped;
      logic [sar_pkg::INTV_W-1:0]         el;
      logic signed [sar_pkg::ANGLE_W+1:0] na;
      logic signed [sar_pkg::ANGLE_W+1:0] g;
      logic signed [sar_pkg::ANGLE_W:0]   diff;
      logic                               snap;
      cur_in    = cur_ff;
      goal_in   = goal_ff;
      step_in   = step_ff;
      active_in = active_ff;
      elap_in   = elap_ff;
      wr_in     = wr_ff;
      steps_in  = steps_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;

      if (tgt_ff[sar_pkg::TARGET_W-1]) begin
         clamped = '0;
      end else if (tgt_ff[15:0] > sar_pkg::ANGLE_MAX_IN) begin
         clamped = sar_pkg::ANGLE_MAX_IN;
      end else begin
         clamped = tgt_ff[15:0];
      end

      el   = (elap_ff == '1) ? elap_ff : elap_ff + 1'b1;
      na   = $signed({2'b00, cur_ff}) + $signed({step_ff[sar_pkg::STEP_W-1], step_ff});
      g    = $signed({2'b00, goal_ff});
      snap = (step_ff == '0)
          || (!step_ff[sar_pkg::STEP_W-1] && (na >= g))
          || (step_ff[sar_pkg::STEP_W-1] && (na <= g));
      diff = $signed({1'b0, goal_ff}) - $signed({1'b0, cur_ff});

      if (cmd.capture) begin
         wr_in = 1'b0;
      end

      if (cmd.tick) begin
         wr_in = 1'b0;
         if (active_ff) begin
            if (el >= intv_eff) begin
               cur_in    = snap ? goal_ff : na[sar_pkg::ANGLE_W-1:0];
               active_in = !snap;
               elap_in   = '0;
               wr_in     = 1'b1;
            end else begin
               elap_in = el;
            end
         end
      end

      if (cmd.move_start) begin
         goal_in = {clamped, 8'd0};
      end

      if (cmd.move_eval) begin
         if (div_quo == '0) begin
            cur_in    = goal_ff;
            active_in = 1'b0;
            wr_in     = 1'b1;
         end else begin
            steps_in = div_quo[sar_pkg::DIV_D_W-1:0];
            neg_in   = diff[sar_pkg::ANGLE_W];
            mag_in   = diff[sar_pkg::ANGLE_W] ? sar_pkg::ANGLE_W'(-diff)
                                              : diff[sar_pkg::ANGLE_W-1:0];
         end
      end

      if (cmd.move_ramp) begin
         // Truncation toward zero: divide the magnitude, then restore the sign.
         step_in   = neg_ff ? -{1'b0, div_quo} : {1'b0, div_quo};
         active_in = 1'b1;
         elap_in   = '0;
         wr_in     = 1'b0;
      end
   end

   assign scaled = sar_pkg::OFF_P_W'(offv_ff[sar_pkg::OFF_V_W-1:sar_pkg::OFF_X_LSB])
                 * sar_pkg::OFF_P_W'(sar_pkg::OFF_RECIP);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff      <= '0;
         intv_ff      <= sar_pkg::INTV_RESET;
         cur_ff       <= '0;
         goal_ff      <= '0;
         step_ff      <= '0;
         active_ff    <= 1'b0;
         elap_ff      <= '0;
         wr_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               sar_pkg::CSR_CHANNEL:  chan_ff <= csr_wdata[sar_pkg::CHAN_W-1:0];
               sar_pkg::CSR_INTERVAL: intv_ff <= csr_wdata[sar_pkg::INTV_W-1:0];
               default: ;
            endcase
         end
         cur_ff       <= cur_in;
         goal_ff      <= goal_in;
         step_ff      <= step_in;
         active_ff    <= active_in;
         elap_ff      <= elap_in;
         wr_ff        <= wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.capture) begin
         mode_ff <= req_mode;
         tgt_ff  <= req_target_angle;
         dur_ff  <= req_duration_ms;
      end
      steps_ff <= steps_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      if (cmd.off_mul) begin
         offv_ff <= sar_pkg::OFF_MUL * sar_pkg::OFF_V_W'(cur_ff) + sar_pkg::OFF_ADD;
      end
      if (cmd.off_scale) begin
         off_ff <= scaled[sar_pkg::OFF_P_W-1:sar_pkg::OFF_X_LSB];
      end
      if (cmd.rsp_load) begin
         rsp_wv_ff   <= wr_ff;
         rsp_ch_ff   <= chan_ff;
         rsp_off_ff  <= wr_ff ? off_ff : '0;
         rsp_done_ff <= !active_ff;
      end
   end

   assign status.div_done   = div_done;
   assign status.steps_zero = (div_quo == '0);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_valid = rsp_wv_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_off_count   = rsp_off_ff;
   assign rsp_move_done   = rsp_done_ff;

   // The captured mode is only kept for the move path check below.
   `SAR_ASSERT(a_div_nonzero, div_start |-> (div_den != '0), "divider started with zero divisor")
   `SAR_ASSERT(a_angle_range, (cur_ff <= ANGLE_LIMIT) && (goal_ff <= ANGLE_LIMIT), "angle out of range")
   `SAR_ASSERT(a_move_mode, cmd.move_start |-> (mode_ff == sar_pkg::MODE_MOVE), "move path on a tick beat")
   `SAR_ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule

FILE: src/sar_ctrl.sv
// Sequencer of the servo ramp: steps the datapath through ticks and moves.
module sar_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   output logic                req_ready,
   input  sar_pkg::status_type status,
   output sar_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK,
      ST_MOVE0,
      ST_DIV1,
      ST_MOVE1,
      ST_DIV2S,
      ST_DIV2,
      ST_MOVE2,
      ST_OFF1,
      ST_OFF2,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_mode == sar_pkg::MODE_MOVE) ? ST_MOVE0 : ST_TICK;
            end
         end
         ST_TICK:  state_in = ST_OFF1;
         ST_MOVE0: state_in = ST_DIV1;
         ST_DIV1: begin
            if (status.div_done) begin
               state_in = ST_MOVE1;
            end
         end
         ST_MOVE1: state_in = status.steps_zero ? ST_OFF1 : ST_DIV2S;
         ST_DIV2S: state_in = ST_DIV2;
         ST_DIV2: begin
            if (status.div_done) begin
               state_in = ST_MOVE2;
            end
         end
         ST_MOVE2: state_in = ST_OFF1;
         ST_OFF1:  state_in = ST_OFF2;
         ST_OFF2:  state_in = ST_RESP;
         ST_RESP: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.capture    = (state_ff == ST_IDLE) && req_valid;
      cmd.tick       = (state_ff == ST_TICK);
      cmd.move_start = (state_ff == ST_MOVE0);
      cmd.move_eval  = (state_ff == ST_MOVE1);
      cmd.div2_start = (state_ff == ST_DIV2S);
      cmd.move_ramp  = (state_ff == ST_MOVE2);
      cmd.off_mul    = (state_ff == ST_OFF1);
      cmd.off_scale  = (state_ff == ST_OFF2);
      cmd.rsp_load   = (state_ff == ST_RESP) && status.rsp_free;
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/servo_angle_ramp.sv
// Top level of the servo angle ramp generator.
//
//   channel  direction  contents
//   req_     in         mode, target_angle, duration_ms (valid/ready)
//   rsp_     out        write_valid, out_channel, off_count, move_done (valid/ready)
//   csr_     in         write enable, index, data (0 channel, 1 update interval)
//
// A tick beat runs the tick step, off count multiply and scale, and result load.
// A move beat whose step count is zero makes one pass of the shared divider, and one
// that starts a ramp makes two; the divider retires two quotient bits a cycle.
// Reset is synchronous and clears all ramp state at once; there is no clearing pass.
// The next beat is accepted while a result waits in the output register; a finished
// beat then holds in the sequencer until the output register is free.
module servo_angle_ramp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic signed [sar_pkg::TARGET_W-1:0] req_target_angle,
   input  logic [sar_pkg::DUR_W-1:0]           req_duration_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_write_valid,
   output logic [sar_pkg::CHAN_W-1:0]          rsp_out_channel,
   output logic [sar_pkg::OFF_W-1:0]           rsp_off_count,
   output logic                                rsp_move_done,
   input  logic                                csr_wr_en,
   input  logic [sar_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sar_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   sar_pkg::cmd_type    cmd;
   sar_pkg::status_type status;

   sar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sar_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_target_angle (req_target_angle),
      .req_duration_ms  (req_duration_ms),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_off_count    (rsp_off_count),
      .rsp_move_done    (rsp_move_done)
   );

endmodule

FILE: sim/tb_servo_angle_ramp.sv
// Self-checking testbench for servo_angle_ramp with a predicting scoreboard and random handshakes.
module tb_servo_angle_ramp;

   localparam int PHASE_ITEMS   = 150;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int TARGET_MAX    = 46080;

   typedef struct packed {
      logic        write_valid;
      logic [3:0]  out_channel;
      logic [11:0] off_count;
      logic        move_done;
   } servo_beat_type;

   class ramp_scoreboard;
      logic [3:0]         channel;
      logic [15:0]        interval;
      logic [23:0]        angle;
      logic [23:0]        goal;
      logic signed [24:0] step;
      bit                 ramping;
      logic [15:0]        elapsed;
      servo_beat_type     expected_q[$];
      int unsigned        errors;

      function new();
         channel  = '0;
         interval = 16'd20;
         angle    = '0;
         goal     = '0;
         step     = '0;
         ramping  = 1'b0;
         elapsed  = '0;
         errors   = 0;
      endfunction

      function void write_reg(logic [sar_pkg::CSR_IDX_W-1:0] idx, logic [15:0] data);
         if (idx == sar_pkg::CSR_CHANNEL) begin
            channel = data[3:0];
         end else if (idx == sar_pkg::CSR_INTERVAL) begin
            interval = data;
         end
      endfunction

      function logic [11:0] pwm_off_count(logic [23:0] a);
         longint unsigned v;
         v = 64'd455 * a + 64'd1342177280;
         return 12'(v / 64'd13107200);
      endfunction

      function void note_beat(logic mode, logic signed [16:0] tgt, logic [15:0] dur);
         int             t;
         int             diff;
         int             na;
         int             g;
         int unsigned    ivl;
         int unsigned    steps;
         bit             wr;
         servo_beat_type res;
         ivl = (interval == 0) ? 1 : interval;
         wr  = 1'b0;
         if (mode == sar_pkg::MODE_MOVE) begin
            t = tgt;
            if (t < 0) t = 0;
            if (t > TARGET_MAX) t = TARGET_MAX;
            goal  = 24'(t * 256);
            steps = dur / ivl;
            if (steps == 0) begin
               angle   = goal;
               ramping = 1'b0;
               wr      = 1'b1;
            end else begin
               // Signed int division truncates toward zero, as the step must.
               diff    = int'(goal) - int'(angle);
               step    = 25'(diff / int'(steps));
               ramping = 1'b1;
               elapsed = '0;
            end
         end else if (ramping) begin
            if (elapsed < 16'hFFFF) elapsed++;
            if (elapsed >= ivl) begin
               na = int'(angle) + int'(step);
               g  = int'(goal);
               if (step == 0 || (step > 0 && na >= g) || (step < 0 && na <= g)) begin
                  na      = g;
                  ramping = 1'b0;
               end
               angle   = 24'(na);
               elapsed = '0;
               wr      = 1'b1;
            end
         end
         res.write_valid = wr;
         res.out_channel = channel;
         res.off_count   = wr ? pwm_off_count(angle) : 12'd0;
         res.move_done   = !ramping;
         expected_q.push_back(res);
      endfunction

      function void check_result(logic wv, logic [3:0] ch, logic [11:0] oc, logic md);
         servo_beat_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $error("response beat arrived with nothing expected");
            return;
         end
         want = expected_q.pop_front();
         if (wv !== want.write_valid) begin
            errors++;
            $error("write_valid: expected %0d, actual %0d", want.write_valid, wv);
         end
         if (ch !== want.out_channel) begin
            errors++;
            $error("out_channel: expected %0d, actual %0d", want.out_channel, ch);
         end
         if (oc !== want.off_count) begin
            errors++;
            $error("off_count: expected %0d, actual %0d", want.off_count, oc);
         end
         if (md !== want.move_done) begin
            errors++;
            $error("move_done: expected %0d, actual %0d", want.move_done, md);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid        = 1'b0;
   logic                                req_ready;
   logic                                req_mode         = sar_pkg::MODE_TICK;
   logic signed [sar_pkg::TARGET_W-1:0] req_target_angle = '0;
   logic [sar_pkg::DUR_W-1:0]           req_duration_ms  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready        = 1'b0;
   logic                                rsp_write_valid;
   logic [sar_pkg::CHAN_W-1:0]          rsp_out_channel;
   logic [sar_pkg::OFF_W-1:0]           rsp_off_count;
   logic                                rsp_move_done;
   logic                                csr_wr_en        = 1'b0;
   logic [sar_pkg::CSR_IDX_W-1:0]       csr_index        = '0;
   logic [sar_pkg::CSR_DATA_W-1:0]      csr_wdata        = '0;

   ramp_scoreboard sb;
   int             beats_sent  = 0;
   int             quiet_left  = 0;
   int             holds_asked = 0;

   always #4 clock = ~clock;

   servo_angle_ramp u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_target_angle (req_target_angle),
      .req_duration_ms  (req_duration_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_off_count    (rsp_off_count),
      .rsp_move_done    (rsp_move_done),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic int pick_target();
      int r;
      r = $urandom_range(0, 19);
      if (r < 16) return $urandom_range(0, TARGET_MAX);
      case (r)
         16: return -int'($urandom_range(1, 65536));
         17: return $urandom_range(TARGET_MAX + 1, 65535);
         18: return TARGET_MAX;
         default: return 0;
      endcase
   endfunction

   task automatic send_beat(logic mode, logic signed [16:0] tgt, logic [15:0] dur);
      int gap;
      gap = (quiet_left > 0) ? 0 : pick_gap();
      if (quiet_left > 0) quiet_left--;
      // Valid only drops when a gap follows, so back-to-back beats keep it high.
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_target_angle <= tgt;
      req_duration_ms  <= dur;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_beat(mode, tgt, dur);
      beats_sent++;
   endtask

   task automatic send_move(int tgt, int dur);
      send_beat(sar_pkg::MODE_MOVE, 17'(tgt), 16'(dur));
   endtask

   task automatic send_ticks(int n);
      for (int i = 0; i < n; i++) begin
         send_beat(sar_pkg::MODE_TICK, 17'($urandom_range(0, 131071)),
                   16'($urandom_range(0, 65535)));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(logic [3:0] chan, logic [15:0] intv);
      logic [15:0] chan_word;
      chan_word = {12'($urandom_range(0, 4095)), chan};
      csr_wr_en <= 1'b1;
      csr_index <= sar_pkg::CSR_CHANNEL;
      csr_wdata <= chan_word;
      @(posedge clock);
      sb.write_reg(sar_pkg::CSR_CHANNEL, chan_word);
      csr_index <= sar_pkg::CSR_INTERVAL;
      csr_wdata <= intv;
      @(posedge clock);
      sb.write_reg(sar_pkg::CSR_INTERVAL, intv);
      csr_wr_en <= 1'b0;
   endtask

   // Response checking on every accepted beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_write_valid, rsp_out_channel, rsp_off_count, rsp_move_done);
      end
   end

   // Receiver pacing, including the long hold-off that backs the block up.
   initial begin : rsp_pacing
      int run;
      int gap;
      int holds_done;
      holds_done = 0;
      forever begin
         if (holds_asked > holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            repeat (run) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int          ph;
      int          ivl_eff;
      int          k;
      int          n;
      int          d;
      int          kind;
      int          base;
      logic [3:0]  chan;
      logic [15:0] intv;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A jump and an idle tick under the reset settings.
      send_move(11520, 0);
      send_ticks(1);
      drain();

      apply_config(4'd15, 16'd2);
      send_ticks(1);                 // idle tick
      send_move(TARGET_MAX, 0);      // zero step count, top of range
      send_move(-65536, 1);          // negative clamp, duration below one interval
      send_move(65535, 4);           // high clamp, two-step ramp up
      send_ticks(4);                 // last step lands exactly on the goal
      send_ticks(1);
      send_move(46079, 6);           // small move down with a truncated step
      send_ticks(8);                 // fourth step overshoots and snaps
      send_move(46079, 2);           // zero step size
      send_ticks(2);
      send_move(0, 65535);           // longest duration
      send_ticks(2);
      send_move(1, 0);               // a jump cuts the ramp short
      drain();

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin chan = 4'd0;  intv = 16'd1;     end
            1: begin chan = 4'd5;  intv = 16'd0;     end
            2: begin chan = 4'd15; intv = 16'd3;     end
            3: begin chan = 4'd9;  intv = 16'd65535; end
            4: begin chan = 4'($urandom_range(0, 15)); intv = 16'($urandom_range(1, 4)); end
            default: begin chan = 4'($urandom_range(0, 15)); intv = 16'd5; end
         endcase
         apply_config(chan, intv);
         ivl_eff = (intv == 0) ? 1 : intv;
         if (ph == 2) begin
            holds_asked++;
            quiet_left = 60;
         end
         base = beats_sent;
         while (beats_sent - base < PHASE_ITEMS) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 7) == 0) quiet_left = $urandom_range(10, 30);
            if (kind <= 6) begin
               // Ramp: a move, then ticks for its k intervals plus up to three, capped at 80.
               k = $urandom_range(0, 6);
               d = k * ivl_eff + $urandom_range(0, ivl_eff - 1);
               if (d > 65535) d = 65535;
               send_move(pick_target(), d);
               n = k * ivl_eff + $urandom_range(0, 3);
               if (n > 80) n = 80;
               send_ticks(n);
            end else if (kind == 7) begin
               send_ticks($urandom_range(1, 5));
            end else if (kind == 8) begin
               send_move($urandom_range(0, 131071), $urandom_range(0, 65535));
               send_ticks($urandom_range(0, 3));
            end else begin
               // Interrupted ramp: a new move lands partway through.
               k = $urandom_range(2, 6);
               d = k * ivl_eff;
               if (d > 65535) d = 65535;
               send_move(pick_target(), d);
               n = $urandom_range(0, k * ivl_eff - 1);
               if (n > 40) n = 40;
               send_ticks(n);
               send_move(pick_target(), $urandom_range(0, 2 * ivl_eff));
            end
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/sar_pkg.sv
src/sar_div.sv
src/sar_datapath.sv
src/sar_ctrl.sv
src/servo_angle_ramp.sv
sim/tb_servo_angle_ramp.sv
